>>> rtl/knps_pkg.sv
`timescale 1ns / 1ps

package knps_pkg;

    // Fixed field widths
    localparam int CNT_W   = 5;
    localparam int DIST_W  = 34;
    localparam int PIDX_W  = 20;
    localparam int COORD_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 34;

    // Request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_OFFER = 2'd1;
    localparam logic [1:0] REQ_DUMP  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS_SQ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 3'd4;

    // Reset values
    localparam logic [DIST_W-1:0] MAX_RADIUS_RESET = {DIST_W{1'b1}};
    localparam logic [CNT_W-1:0]  NEIGHBOR_RESET   = 5'd16;

    // Most entries one dump reports
    localparam logic [CNT_W-1:0]  DUMP_CAP = 5'd16;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [PIDX_W-1:0]         point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic              entry_valid;
        logic [PIDX_W-1:0] kept_index;
        logic [DIST_W-1:0] kept_distance_sq;
        logic              accepted;
        logic [CNT_W-1:0]  kept_count;
        logic [DIST_W-1:0] bound_sq;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_z;
        logic [DIST_W-1:0]         max_radius_sq;
        logic [CNT_W-1:0]          neighbor_count;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [PIDX_W-1:0] point;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_HREAD,
        ST_HLOAD,
        ST_SREAD,
        ST_SCMP,
        ST_EMIT,
        ST_DRD,
        ST_DOUT
    } t_state;

endpackage

>>> rtl/k_nearest_point_selector_top.sv
`timescale 1ns / 1ps

// K-nearest point selector.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one request per
// transfer: start a query, offer a candidate point, or dump the kept entries.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one status
// result per start, offer or unknown request, and one result per kept entry
// (up to 16, last flagged) per dump; an empty dump gives one status result.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
// written by the user only while the block is idle, which the block itself does not enforce.
// The block takes one request at a time. A start goes through the emit state
// to its result. An offer forms its distance and then emits when appended or
// rejected; a root replacement adds, per heap level walked, one dual-port
// memory read and one compare and write back. The offer that fills the store
// also builds the heap, one sift per internal node. A dump reads each entry
// from memory and then outputs it, one entry at a time.
// Reset clears the count, sets the bound to the maximum radius and loads the
// register defaults; heap memory needs no clearing. A stalled receiver holds
// the output register; the block still takes the next request and stops at
// its own first result until the register frees.
module k_nearest_point_selector_top #(
    parameter int MAX_NEIGHBORS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [knps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [knps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  knps_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output knps_pkg::t_out_item                  o_out_data
);

    localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    knps_pkg::t_cfg               r_cfg;
    logic [knps_pkg::DIST_W-1:0]  cand_dist;
    logic                         we, re;
    logic [AW-1:0]                waddr, raddr_a, raddr_b;
    knps_pkg::t_entry             wdata, rdata_a, rdata_b;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{query_x: '0, query_y: '0, query_z: '0,
                       max_radius_sq: knps_pkg::MAX_RADIUS_RESET,
                       neighbor_count: knps_pkg::NEIGHBOR_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                knps_pkg::CFG_QUERY_X:        r_cfg.query_x <= i_cfg_data[15:0];
                knps_pkg::CFG_QUERY_Y:        r_cfg.query_y <= i_cfg_data[15:0];
                knps_pkg::CFG_QUERY_Z:        r_cfg.query_z <= i_cfg_data[15:0];
                knps_pkg::CFG_MAX_RADIUS_SQ:  r_cfg.max_radius_sq <= i_cfg_data;
                knps_pkg::CFG_NEIGHBOR_COUNT: r_cfg.neighbor_count <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    knps_dist u_dist (
        .i_clk  (i_clk),
        .i_load (i_in_valid && o_in_ready),
        .i_item (i_in_data),
        .i_cfg  (r_cfg),
        .o_dist (cand_dist)
    );

    knps_mem #(
        .DEPTH (MAX_NEIGHBORS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    knps_ctrl #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .AW            (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_dist      (cand_dist),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

`ifndef ASSERT_OFF
    // Count never exceeds the store depth
    a_count_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.kept_count) <= MAX_NEIGHBORS))
        else $error("kept count beyond store depth");

    // Dump entries come only from a non-empty store and never flag acceptance
    a_entry_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.entry_valid) |->
        ((o_out_data.kept_count != '0) && !o_out_data.accepted))
        else $error("dump entry from empty store");

    // Status results stand alone
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.entry_valid) |-> o_out_data.last)
        else $error("status result without last");
`endif

endmodule

>>> rtl/knps_mem.sv
`timescale 1ns / 1ps

module knps_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  knps_pkg::t_entry  i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output knps_pkg::t_entry  o_rdata_a,
    output knps_pkg::t_entry  o_rdata_b
);

    knps_pkg::t_entry r_mem [DEPTH];
    knps_pkg::t_entry r_rdata_a;
    knps_pkg::t_entry r_rdata_b;

    // Write one entry, read two; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/knps_dist.sv
`timescale 1ns / 1ps

module knps_dist (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  knps_pkg::t_in_item                    i_item,
    input  knps_pkg::t_cfg                        i_cfg,
    output logic [knps_pkg::DIST_W-1:0]           o_dist
);

    logic signed [knps_pkg::COORD_W:0]     dx, dy, dz;
    logic signed [2*knps_pkg::COORD_W+1:0] px, py, pz;
    logic [2*knps_pkg::COORD_W-1:0]        r_sq_x, r_sq_y, r_sq_z;

    // Form the differences and square them
    always_comb begin
        dx = $signed({i_item.point_x[knps_pkg::COORD_W-1], i_item.point_x})
           - $signed({i_cfg.query_x[knps_pkg::COORD_W-1], i_cfg.query_x});
        dy = $signed({i_item.point_y[knps_pkg::COORD_W-1], i_item.point_y})
           - $signed({i_cfg.query_y[knps_pkg::COORD_W-1], i_cfg.query_y});
        dz = $signed({i_item.point_z[knps_pkg::COORD_W-1], i_item.point_z})
           - $signed({i_cfg.query_z[knps_pkg::COORD_W-1], i_cfg.query_z});
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    // Register the squares; each is below 2^32
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sq_x <= px[2*knps_pkg::COORD_W-1:0];
            r_sq_y <= py[2*knps_pkg::COORD_W-1:0];
            r_sq_z <= pz[2*knps_pkg::COORD_W-1:0];
        end
    end

    assign o_dist = knps_pkg::DIST_W'(r_sq_x) + knps_pkg::DIST_W'(r_sq_y)
                  + knps_pkg::DIST_W'(r_sq_z);

endmodule

>>> rtl/knps_ctrl.sv
`timescale 1ns / 1ps

module knps_ctrl #(
    parameter int MAX_NEIGHBORS = 16,
    parameter int AW            = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  knps_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  knps_pkg::t_in_item            i_in_data,
    input  logic [knps_pkg::DIST_W-1:0]   i_dist,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output knps_pkg::t_out_item           o_out_data,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output knps_pkg::t_entry              o_wdata,
    output logic                          o_re,
    output logic [AW-1:0]                 o_raddr_a,
    output logic [AW-1:0]                 o_raddr_b,
    input  knps_pkg::t_entry              i_rdata_a,
    input  knps_pkg::t_entry              i_rdata_b
);

    localparam int CW = knps_pkg::CNT_W;
    localparam int LW = (AW + 2 > CW) ? AW + 2 : CW;

    knps_pkg::t_state r_state, n_state;
    logic [CW-1:0]                 r_held, n_held;
    logic [knps_pkg::DIST_W-1:0]   r_bound, n_bound;
    logic                          r_out_valid;
    knps_pkg::t_out_item           r_out, n_out;
    logic                          out_load;

    logic [knps_pkg::PIDX_W-1:0]   r_pidx, n_pidx;
    knps_pkg::t_entry              r_cand, n_cand;
    logic [AW-1:0]                 r_parent, n_parent;
    logic [LW-1:0]                 r_child, n_child;
    logic [CW-1:0]                 r_n, n_n;
    logic                          r_heapify, n_heapify;
    logic [AW-1:0]                 r_j, n_j;
    logic [AW-1:0]                 r_i, n_i;
    logic [CW-1:0]                 r_dn, n_dn;
    logic                          r_acc, n_acc;

    logic [CW-1:0]     k, half_k, dump_n;
    logic              slot_free;
    logic [LW-1:0]     child_w, child_b;
    logic              has_b, pick_b, sift_end;
    knps_pkg::t_entry  sel;
    logic [LW-1:0]     sel_idx;

    // Clamp the neighbor count into one .. MAX_NEIGHBORS
    always_comb begin
        if (i_cfg.neighbor_count == '0) begin
            k = CW'(1);
        end else if (32'(i_cfg.neighbor_count) > MAX_NEIGHBORS) begin
            k = CW'(MAX_NEIGHBORS);
        end else begin
            k = i_cfg.neighbor_count;
        end
        half_k = (k - CW'(2)) >> 1;
        dump_n = (r_held > knps_pkg::DUMP_CAP) ? knps_pkg::DUMP_CAP : r_held;
    end

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == knps_pkg::ST_IDLE);

    // Child selection for one sift level
    always_comb begin
        child_w = (LW'(r_parent) << 1) + LW'(1);
        child_b = r_child + LW'(1);
        has_b   = child_b < LW'(r_n);
        pick_b  = has_b && (i_rdata_a.dist_sq < i_rdata_b.dist_sq);
        sel     = pick_b ? i_rdata_b : i_rdata_a;
        sel_idx = pick_b ? child_b : r_child;
    end

    // Next state, memory access and result formation
    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_bound   = r_bound;
        n_pidx    = r_pidx;
        n_cand    = r_cand;
        n_parent  = r_parent;
        n_child   = r_child;
        n_n       = r_n;
        n_heapify = r_heapify;
        n_j       = r_j;
        n_i       = r_i;
        n_dn      = r_dn;
        n_acc     = r_acc;
        n_out     = r_out;
        out_load  = 1'b0;
        o_we      = 1'b0;
        o_waddr   = r_parent;
        o_wdata   = r_cand;
        o_re      = 1'b0;
        o_raddr_a = r_j;
        o_raddr_b = r_j;
        sift_end  = 1'b0;

        case (r_state)
            knps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_acc = 1'b0;
                    case (i_in_data.req_type)
                        knps_pkg::REQ_START: begin
                            n_held  = '0;
                            n_bound = i_cfg.max_radius_sq;
                            n_state = knps_pkg::ST_EMIT;
                        end
                        knps_pkg::REQ_OFFER: begin
                            n_pidx  = i_in_data.point_index;
                            n_state = knps_pkg::ST_DIST;
                        end
                        knps_pkg::REQ_DUMP: begin
                            if (dump_n == '0) begin
                                n_state = knps_pkg::ST_EMIT;
                            end else begin
                                n_i     = '0;
                                n_dn    = dump_n;
                                n_state = knps_pkg::ST_DRD;
                            end
                        end
                        default: begin
                            n_state = knps_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            knps_pkg::ST_DIST: begin
                n_state = knps_pkg::ST_EMIT;
                if (i_dist < r_bound) begin
                    n_acc = 1'b1;
                    if (r_held < k) begin
                        // Append while the store fills
                        o_we       = 1'b1;
                        o_waddr    = AW'(LW'(r_held));
                        o_wdata    = '{dist_sq: i_dist, point: r_pidx};
                        n_held     = r_held + CW'(1);
                        if (r_held + CW'(1) == k) begin
                            if (k >= CW'(2)) begin
                                n_heapify = 1'b1;
                                n_j       = AW'(LW'(half_k));
                                n_state   = knps_pkg::ST_HREAD;
                            end else begin
                                n_bound = i_dist;
                            end
                        end
                    end else begin
                        // Replace the root and sift down
                        n_cand    = '{dist_sq: i_dist, point: r_pidx};
                        n_parent  = '0;
                        n_n       = r_held;
                        n_heapify = 1'b0;
                        n_state   = knps_pkg::ST_SREAD;
                    end
                end
            end

            knps_pkg::ST_HREAD: begin
                o_re      = 1'b1;
                o_raddr_a = r_j;
                o_raddr_b = r_j;
                n_state   = knps_pkg::ST_HLOAD;
            end

            knps_pkg::ST_HLOAD: begin
                n_cand   = i_rdata_a;
                n_parent = r_j;
                n_n      = r_held;
                n_state  = knps_pkg::ST_SREAD;
            end

            knps_pkg::ST_SREAD: begin
                if (child_w < LW'(r_n)) begin
                    o_re      = 1'b1;
                    o_raddr_a = child_w[AW-1:0];
                    o_raddr_b = (child_w + LW'(1) < LW'(r_n)) ?
                                AW'(child_w + LW'(1)) : child_w[AW-1:0];
                    n_child   = child_w;
                    n_state   = knps_pkg::ST_SCMP;
                end else begin
                    // Leaf reached: place the value
                    o_we     = 1'b1;
                    o_waddr  = r_parent;
                    o_wdata  = r_cand;
                    sift_end = 1'b1;
                    if (r_parent == '0) begin
                        n_bound = r_cand.dist_sq;
                    end
                end
            end

            knps_pkg::ST_SCMP: begin
                o_we    = 1'b1;
                o_waddr = r_parent;
                if (r_cand.dist_sq > sel.dist_sq) begin
                    o_wdata  = r_cand;
                    sift_end = 1'b1;
                    if (r_parent == '0) begin
                        n_bound = r_cand.dist_sq;
                    end
                end else begin
                    // Move the larger child up; ties move the new value down
                    o_wdata  = sel;
                    n_parent = sel_idx[AW-1:0];
                    n_state  = knps_pkg::ST_SREAD;
                    if (r_parent == '0) begin
                        n_bound = sel.dist_sq;
                    end
                end
            end

            knps_pkg::ST_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_out    = '{entry_valid: 1'b0, kept_index: '0, kept_distance_sq: '0,
                                 accepted: r_acc, kept_count: r_held, bound_sq: r_bound,
                                 last: 1'b1};
                    n_state  = knps_pkg::ST_IDLE;
                end
            end

            knps_pkg::ST_DRD: begin
                o_re      = 1'b1;
                o_raddr_a = r_i;
                o_raddr_b = r_i;
                n_state   = knps_pkg::ST_DOUT;
            end

            knps_pkg::ST_DOUT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_out    = '{entry_valid: 1'b1, kept_index: i_rdata_a.point,
                                 kept_distance_sq: i_rdata_a.dist_sq, accepted: 1'b0,
                                 kept_count: r_held, bound_sq: r_bound,
                                 last: (LW'(r_i) + LW'(1) == LW'(r_dn))};
                    if (LW'(r_i) + LW'(1) == LW'(r_dn)) begin
                        n_state = knps_pkg::ST_IDLE;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = knps_pkg::ST_DRD;
                    end
                end
            end

            default: begin
                n_state = knps_pkg::ST_IDLE;
            end
        endcase

        // Advance to the next heapify slot or report
        if (sift_end) begin
            if (r_heapify && (r_j != '0)) begin
                n_j     = r_j - AW'(1);
                n_state = knps_pkg::ST_HREAD;
            end else begin
                n_state = knps_pkg::ST_EMIT;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= knps_pkg::ST_IDLE;
            r_held      <= '0;
            r_bound     <= knps_pkg::MAX_RADIUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_bound <= n_bound;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_pidx    <= n_pidx;
        r_cand    <= n_cand;
        r_parent  <= n_parent;
        r_child   <= n_child;
        r_n       <= n_n;
        r_heapify <= n_heapify;
        r_j       <= n_j;
        r_i       <= n_i;
        r_dn      <= n_dn;
        r_acc     <= n_acc;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
